[rtl/core/battery_history_sample_logger_assert.svh]
`ifndef BATTERY_HISTORY_SAMPLE_LOGGER_ASSERT_SVH
`define BATTERY_HISTORY_SAMPLE_LOGGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BHSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhsl assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define BHSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhsl assertion failed");

`endif

[rtl/core/bhsl_pkg.sv]
package bhsl_pkg;

    localparam int HIST_DEPTH = 64;
    localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    localparam logic [31:0] INTERVAL_RESET = 32'd300000000;
    localparam logic [2:0]  CHG_LAST_CODE  = 3'd3;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [31:0] hour;
        logic [15:0] volt;
        logic [6:0]  pct;
        logic        flag_charging;
        logic        flag_external;
        logic        flag_valid;
    } hist_point_t;

    typedef struct packed
    {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        hist_point_t       wdata;
    } mem_req_t;

    // sum below twice the depth folds back with one compare and subtract
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] r;
        begin
            r = (v >= SUM_W'(HIST_DEPTH)) ? (v - SUM_W'(HIST_DEPTH)) : v;
            return r[SLOT_W-1:0];
        end
    endfunction

endpackage

[rtl/core/bhsl_if.sv]
interface bhsl_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [62:0] now_us;
    logic [31:0] hour_tag;
    logic        sample_valid;
    logic        pct_present;
    logic [6:0]  percentage;
    logic        has_voltage;
    logic [13:0] volt_mv;
    logic        ext_supply;
    logic [2:0]  charge_code;
    logic        force_req;
    logic [5:0]  read_index;

    modport source
    (
        output valid, op, now_us, hour_tag, sample_valid, pct_present, percentage,
               has_voltage, volt_mv, ext_supply, charge_code, force_req, read_index,
        input  ready
    );

    modport sink
    (
        input  valid, op, now_us, hour_tag, sample_valid, pct_present, percentage,
               has_voltage, volt_mv, ext_supply, charge_code, force_req, read_index,
        output ready
    );
endinterface

interface bhsl_out_if;
    logic        valid;
    logic        ready;
    logic        persist;
    logic        cycle_reset;
    logic [6:0]  point_total;
    logic [6:0]  sess_start_pct;
    logic        sess_src_ext;
    logic        entry_valid;
    logic [31:0] entry_hour;
    logic [15:0] entry_volt_mv;
    logic [6:0]  entry_percentage;
    logic        entry_external;
    logic        entry_charging;

    modport source
    (
        output valid, persist, cycle_reset, point_total, sess_start_pct,
               sess_src_ext, entry_valid, entry_hour, entry_volt_mv,
               entry_percentage, entry_external, entry_charging,
        input  ready
    );

    modport sink
    (
        input  valid, persist, cycle_reset, point_total, sess_start_pct,
               sess_src_ext, entry_valid, entry_hour, entry_volt_mv,
               entry_percentage, entry_external, entry_charging,
        output ready
    );
endinterface

[rtl/core/bhsl_hist_mem.sv]
module bhsl_hist_mem
    import bhsl_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    output hist_point_t rdata
);

    hist_point_t mem [HIST_DEPTH];
    hist_point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/battery_history_sample_logger.sv]
// channel   dir   payload
// in_ch     in    op, now_us, hour tag, sample qualifiers, readings, read_index
// out_ch    out   persist, cycle_reset, count, session, read point fields
// cfg       in    cfg_we / cfg_wdata: sample_interval_us
//
// an item goes through transfer and history memory read, then evaluate and write back
// the evaluate cycle waits while the output register holds a result not yet taken
// the output register lets the next input transfer while a result waits
// reset clears control state only; history memory contents are undefined until written
module battery_history_sample_logger
    import bhsl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata,
    bhsl_in_if.sink          in_ch,
    bhsl_out_if.source       out_ch
);

    typedef enum logic
    {
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef struct packed
    {
        logic        persist;
        logic        cycle_reset;
        logic [6:0]  point_total;
        logic [6:0]  sess_start_pct;
        logic        sess_src_ext;
        logic        entry_valid;
        logic [31:0] entry_hour;
        logic [15:0] entry_volt_mv;
        logic [6:0]  entry_percentage;
        logic        entry_external;
        logic        entry_charging;
    } result_t;

    state_t            state_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    logic [31:0]       interval_reg;
    logic [SLOT_W-1:0] oldest_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              known_reg;
    logic              sess_ext_reg;
    logic [6:0]        sess_pct_reg;
    logic [63:0]       nst_reg;

    // latched item
    logic              op_read_reg;
    logic              take_reg;
    logic              due_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [62:0]       now_reg;
    logic [31:0]       hour_reg;
    logic [6:0]        pct_reg;
    logic [15:0]       volt_reg;
    logic              ext_reg;
    logic              chg_reg;

    logic              accept;
    logic [SLOT_W-1:0] read_slot;
    logic              due;
    logic              take;
    logic              hit;

    mem_req_t          mem_req;
    hist_point_t       rdata;

    logic              out_load;
    logic              new_sess;
    logic              do_write;
    logic              same_hour;
    logic              full;
    logic [SLOT_W-1:0] app_slot;
    logic [CNT_W-1:0]  cnt_next;
    logic              append;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (in_ch.op == OP_READ)
        begin
            read_slot = wrap_slot(SUM_W'(oldest_reg) + SUM_W'(in_ch.read_index));
        end
        else
        begin
            read_slot = wrap_slot(SUM_W'(oldest_reg) + SUM_W'(cnt_reg) - SUM_W'(1));
        end
        due  = in_ch.force_req || (nst_reg == 64'd0) || ({1'b0, in_ch.now_us} >= nst_reg);
        take = (in_ch.op == OP_SAMPLE) && in_ch.sample_valid && in_ch.pct_present;
        hit  = SUM_W'(in_ch.read_index) < SUM_W'(cnt_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_read_reg <= (in_ch.op == OP_READ);
            take_reg    <= take;
            due_reg     <= due;
            hit_reg     <= hit;
            slot_reg    <= read_slot;
            now_reg     <= in_ch.now_us;
            hour_reg    <= in_ch.hour_tag;
            pct_reg     <= in_ch.percentage;
            volt_reg    <= in_ch.has_voltage ? {2'b00, in_ch.volt_mv} : 16'd0;
            ext_reg     <= in_ch.ext_supply;
            chg_reg     <= (in_ch.charge_code <= CHG_LAST_CODE);
        end
    end

    always_comb
    begin
        out_load  = (state_reg == ST_EVAL) && (!out_valid_reg || out_ch.ready);
        new_sess  = take_reg && (!known_reg || (sess_ext_reg != ext_reg));
        do_write  = take_reg && (new_sess || due_reg);
        same_hour = (cnt_reg != '0) && (rdata.hour == hour_reg);
        full      = (cnt_reg >= CNT_W'(HIST_DEPTH));
        app_slot  = wrap_slot(SUM_W'(oldest_reg) + SUM_W'(cnt_reg));
        append    = do_write && !same_hour;
        cnt_next  = (append && !full) ? (cnt_reg + CNT_W'(1)) : cnt_reg;

        mem_req.re                  = accept;
        mem_req.raddr               = read_slot;
        mem_req.we                  = do_write && out_load;
        mem_req.waddr               = same_hour ? slot_reg : app_slot;
        mem_req.wdata.hour          = hour_reg;
        mem_req.wdata.volt          = volt_reg;
        mem_req.wdata.pct           = pct_reg;
        mem_req.wdata.flag_charging = chg_reg;
        mem_req.wdata.flag_external = ext_reg;
        mem_req.wdata.flag_valid    = 1'b1;

        out_next.persist          = new_sess || append;
        out_next.cycle_reset      = new_sess;
        out_next.point_total      = 7'(cnt_next);
        out_next.sess_start_pct   = new_sess ? pct_reg : sess_pct_reg;
        out_next.sess_src_ext     = new_sess ? ext_reg : sess_ext_reg;
        out_next.entry_valid      = 1'b0;
        out_next.entry_hour       = 32'd0;
        out_next.entry_volt_mv    = 16'd0;
        out_next.entry_percentage = 7'd0;
        out_next.entry_external   = 1'b0;
        out_next.entry_charging   = 1'b0;
        if (op_read_reg && hit_reg)
        begin
            out_next.entry_valid      = rdata.flag_valid;
            out_next.entry_hour       = rdata.hour;
            out_next.entry_volt_mv    = rdata.volt;
            out_next.entry_percentage = rdata.pct;
            out_next.entry_external   = rdata.flag_external;
            out_next.entry_charging   = rdata.flag_charging;
        end
    end

    bhsl_hist_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (out_load)
                    begin
                        out_reg       <= out_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            oldest_reg   <= '0;
            cnt_reg      <= '0;
            known_reg    <= 1'b0;
            sess_ext_reg <= 1'b0;
            sess_pct_reg <= 7'd0;
            nst_reg      <= 64'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                if (new_sess)
                begin
                    known_reg    <= 1'b1;
                    sess_ext_reg <= ext_reg;
                    sess_pct_reg <= pct_reg;
                end
                if (do_write)
                begin
                    // sum of a 63-bit time and a 32-bit interval cannot pass 64 bits
                    nst_reg <= {1'b0, now_reg} + 64'(interval_reg);
                end
                cnt_reg <= cnt_next;
                if (append && full)
                begin
                    oldest_reg <= wrap_slot(SUM_W'(oldest_reg) + SUM_W'(1));
                end
            end
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.persist          = out_reg.persist;
    assign out_ch.cycle_reset      = out_reg.cycle_reset;
    assign out_ch.point_total      = out_reg.point_total;
    assign out_ch.sess_start_pct   = out_reg.sess_start_pct;
    assign out_ch.sess_src_ext     = out_reg.sess_src_ext;
    assign out_ch.entry_valid      = out_reg.entry_valid;
    assign out_ch.entry_hour       = out_reg.entry_hour;
    assign out_ch.entry_volt_mv    = out_reg.entry_volt_mv;
    assign out_ch.entry_percentage = out_reg.entry_percentage;
    assign out_ch.entry_external   = out_reg.entry_external;
    assign out_ch.entry_charging   = out_reg.entry_charging;

endmodule

[rtl/core/bhsl_checker.sv]
`include "battery_history_sample_logger_assert.svh"

module bhsl_checker
    import bhsl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       persist,
    input logic       cycle_reset,
    input logic [6:0] point_total,
    input logic       entry_valid
);

    // waiting result stays up
    `BHSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    // one item in flight
    `BHSL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // a new session always asks for a save
    `BHSL_ASSERT_NOW(a_session_persists, out_valid && cycle_reset, persist)
    `BHSL_ASSERT_NOW(a_count_bound, out_valid, point_total <= 7'(HIST_DEPTH))
    // a read never changes state
    `BHSL_ASSERT_NOW(a_read_quiet, out_valid && entry_valid, !persist && !cycle_reset)

endmodule

bind battery_history_sample_logger bhsl_checker u_bhsl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .persist     (out_ch.persist),
    .cycle_reset (out_ch.cycle_reset),
    .point_total (out_ch.point_total),
    .entry_valid (out_ch.entry_valid)
);
